@@ hdl/dtd_pkg.sv @@
`default_nettype none
package dtd_pkg;

    localparam int MAX_WINDOW = 1024;
    localparam int ADDR_W     = $clog2(MAX_WINDOW);
    localparam int WIN_W      = ADDR_W + 1;
    localparam int SAMPLE_W   = 24;
    localparam int CNT_W      = 24;
    localparam int THR_W      = 26;
    localparam int ABOVE_W    = 11;
    localparam int DEAD_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 26;

    localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [ABOVE_W-1:0] ABOVE_MAX = {ABOVE_W{1'b1}};

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_SLOPE_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_COUNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_TIME       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RECORD_LENGTH   = 3'd4;

    // reset values
    localparam logic [THR_W-1:0]   RST_SLOPE_THRESHOLD = '0;
    localparam logic [WIN_W-1:0]   RST_WINDOW_LENGTH   = 11'd20;
    localparam logic [ABOVE_W-1:0] RST_DEBOUNCE_COUNT  = 11'd2;
    localparam logic [DEAD_W-1:0]  RST_DEAD_TIME       = 16'd200;
    localparam logic [CNT_W-1:0]   RST_RECORD_LENGTH   = 24'd20000;

endpackage
`default_nettype wire

@@ hdl/dtd_ram.sv @@
`default_nettype none
// Simple dual-port RAM, registered read, read-first on address collision.
module dtd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

@@ hdl/derivative_trigger_debounce_core.sv @@
`default_nettype none
// Derivative pulse trigger with debounce.
// Input channel (s_*): one ADC sample word per transfer, s_last_sample marks
// the final sample of a record. Result channel (m_*): exactly one word per
// input word, in order: trigger flag, running trigger count of the record
// and record_done (a copy of last_sample).
// Config channel (cfg_*): register index and data, always ready; write only
// while no sample is in flight.
// An accepted sample moves to the stage 1 register, then to the output
// register (m_valid); a stall can hold it in stage 1. Throughput: one word
// per clock unless stalled; the RAM port pair sets the pace. Stage 0 writes
// the sample into the delay-line RAM and reads the sample W positions back
// (read-first, so W = 1024 reads the old slot); stage 1 forms the delta, runs
// the debounce counter and dead-time logic, and loads the output register.
// Stall: when m_ready is low the output register holds, the compare stage
// holds with its RAM data, and s_ready drops once both are full.
// Reset (aresetn low, synchronous): registers to their defaults, record state
// cleared, pipeline emptied. Delay-line contents are not cleared; a slot is
// written before it is first read in normal use.
module derivative_trigger_debounce_core
    import dtd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // config
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // samples in
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [SAMPLE_W-1:0]   s_sample,
    input  wire logic                  s_last_sample,
    // results out
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_trigger,
    output logic [CNT_W-1:0]           m_trigger_count,
    output logic                       m_record_done
);

    // ---------------- configuration registers
    logic signed [THR_W-1:0] slope_threshold_reg;
    logic [WIN_W-1:0]        window_length_reg;
    logic [ABOVE_W-1:0]      debounce_count_reg;
    logic [DEAD_W-1:0]       dead_time_reg;
    logic [CNT_W-1:0]        record_length_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slope_threshold_reg <= RST_SLOPE_THRESHOLD;
            window_length_reg   <= RST_WINDOW_LENGTH;
            debounce_count_reg  <= RST_DEBOUNCE_COUNT;
            dead_time_reg       <= RST_DEAD_TIME;
            record_length_reg   <= RST_RECORD_LENGTH;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_SLOPE_THRESHOLD: slope_threshold_reg <= cfg_data[THR_W-1:0];
                REG_WINDOW_LENGTH:   window_length_reg   <= cfg_data[WIN_W-1:0];
                REG_DEBOUNCE_COUNT:  debounce_count_reg  <= cfg_data[ABOVE_W-1:0];
                REG_DEAD_TIME:       dead_time_reg       <= cfg_data[DEAD_W-1:0];
                REG_RECORD_LENGTH:   record_length_reg   <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // effective window: 0 acts as 1, clamp at MAX_WINDOW
    logic [WIN_W-1:0] win;
    always_comb begin
        if (window_length_reg == '0) begin
            win = WIN_W'(1);
        end else if (window_length_reg > WIN_W'(MAX_WINDOW)) begin
            win = WIN_W'(MAX_WINDOW);
        end else begin
            win = window_length_reg;
        end
    end

    // ---------------- handshake
    logic s1_valid_reg;
    logic m_valid_reg;
    logic advance;
    logic accept;

    assign advance = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || advance;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    // ---------------- stage 0: RAM access, index arithmetic
    logic [ADDR_W-1:0] wr_ptr_reg;
    logic [CNT_W-1:0]  sample_index_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              j_ge_w;
    logic [CNT_W-1:0]  k_pos;
    logic signed [CNT_W+1:0] limit;
    logic              below_limit;

    assign rd_addr = wr_ptr_reg - win[ADDR_W-1:0];
    assign j_ge_w  = sample_index_reg >= CNT_W'(win);
    assign k_pos   = sample_index_reg - CNT_W'(win);
    assign limit   = $signed({2'b00, record_length_reg})
                   - $signed((CNT_W+2)'(win))
                   - $signed((CNT_W+2)'(dead_time_reg));
    assign below_limit = $signed({2'b00, k_pos}) < limit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg       <= '0;
            sample_index_reg <= '0;
        end else if (accept) begin
            if (s_last_sample) begin
                wr_ptr_reg       <= '0;
                sample_index_reg <= '0;
            end else begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
                if (sample_index_reg != CNT_MAX) begin
                    sample_index_reg <= sample_index_reg + 1'b1;
                end
            end
        end
    end

    logic [SAMPLE_W-1:0] old_sample;

    dtd_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(MAX_WINDOW)
    ) u_delay_line (
        .aclk  (aclk),
        .we    (accept),
        .waddr (wr_ptr_reg),
        .wdata (s_sample),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (old_sample)
    );

    // stage 1 pipeline register
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic                s1_last_reg;
    logic [CNT_W-1:0]    s1_k_reg;
    logic                s1_pre_eval_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_sample_reg   <= s_sample;
            s1_last_reg     <= s_last_sample;
            s1_k_reg        <= k_pos;
            s1_pre_eval_reg <= j_ge_w && below_limit;
        end
    end

    // ---------------- stage 1: delta, debounce, dead time
    logic [ABOVE_W-1:0] above_reg, above_next;
    logic [CNT_W-1:0]   nas_reg, nas_next;
    logic [CNT_W-1:0]   found_reg, found_next;
    logic               trig;
    logic               eval;
    logic signed [SAMPLE_W:0] delta;
    logic [ABOVE_W-1:0] above_inc;
    logic [CNT_W:0]     nas_sum;

    assign eval      = s1_pre_eval_reg && (s1_k_reg >= nas_reg);
    assign delta     = $signed({s1_sample_reg[SAMPLE_W-1], s1_sample_reg})
                     - $signed({old_sample[SAMPLE_W-1], old_sample});
    assign above_inc = (above_reg != ABOVE_MAX) ? above_reg + 1'b1 : above_reg;
    assign nas_sum   = {1'b0, s1_k_reg} + (CNT_W+1)'(dead_time_reg) + 1'b1;

    always_comb begin
        above_next = above_reg;
        nas_next   = nas_reg;
        found_next = found_reg;
        trig       = 1'b0;
        if (eval) begin
            if ($signed(THR_W'(delta)) > slope_threshold_reg) begin
                above_next = above_inc;
                if (above_inc == debounce_count_reg) begin
                    trig       = 1'b1;
                    above_next = '0;
                    if (found_reg != CNT_MAX) begin
                        found_next = found_reg + 1'b1;
                    end
                    nas_next = nas_sum[CNT_W] ? CNT_MAX : nas_sum[CNT_W-1:0];
                end
            end else begin
                above_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            above_reg <= '0;
            nas_reg   <= '0;
            found_reg <= '0;
        end else if (advance) begin
            if (s1_last_reg) begin
                above_reg <= '0;
                nas_reg   <= '0;
                found_reg <= '0;
            end else begin
                above_reg <= above_next;
                nas_reg   <= nas_next;
                found_reg <= found_next;
            end
        end
    end

    // ---------------- output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_trigger       <= trig;
            m_trigger_count <= found_next;
            m_record_done   <= s1_last_reg;
        end
    end

endmodule
`default_nettype wire

@@ tb/sv/tb_derivative_trigger_debounce_core.sv @@
`timescale 1ns / 1ps

module tb_derivative_trigger_debounce_core;
    import dtd_pkg::*;

    // --------------------------------------------------------------------
    // Run shape
    // --------------------------------------------------------------------
    localparam int RANDOM_WORDS   = 1450;  // no new records once this many traced words went in
    localparam int MAX_IDLE       = 10;    // longest per-word gap / stall
    localparam int HOLD_CYCLES    = 300;   // one long back-pressure stretch on the result side
    localparam int WATCHDOG_LIMIT = 3000;  // cycles with no handshake at all
    localparam int SAMPLE_MAX     = (1 << (SAMPLE_W - 1)) - 1;
    localparam int SAMPLE_MIN     = -(1 << (SAMPLE_W - 1));

    // index past the register map; the block must ignore writes to it
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    typedef struct packed {
        logic             trigger;
        logic [CNT_W-1:0] count;
        logic             done;
    } trig_word_t;

    // --------------------------------------------------------------------
    // Trigger tracker: own copy of registers and record state, one expected
    // result word per accepted sample word, checked in order.
    // --------------------------------------------------------------------
    class trigger_tracker;
        logic signed [THR_W-1:0] thr;
        logic [WIN_W-1:0]        win;
        logic [ABOVE_W-1:0]      deb;
        logic [DEAD_W-1:0]       dead;
        logic [CNT_W-1:0]        rec_len;

        logic [SAMPLE_W-1:0]     taps [MAX_WINDOW];
        logic [ADDR_W-1:0]       wr_ptr;
        logic [CNT_W-1:0]        idx;
        logic [ABOVE_W-1:0]      above;
        logic [CNT_W-1:0]        next_start;
        logic [CNT_W-1:0]        found;

        trig_word_t              due_triggers [$];
        int                      errors;

        function new();
            thr     = RST_SLOPE_THRESHOLD;
            win     = RST_WINDOW_LENGTH;
            deb     = RST_DEBOUNCE_COUNT;
            dead    = RST_DEAD_TIME;
            rec_len = RST_RECORD_LENGTH;
            errors  = 0;
            clear_record();
        endfunction

        function void clear_record();
            wr_ptr     = '0;
            idx        = '0;
            above      = '0;
            next_start = '0;
            found      = '0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] sel, logic [CFG_DATA_W-1:0] data);
            case (sel)
                REG_SLOPE_THRESHOLD: thr     = data[THR_W-1:0];
                REG_WINDOW_LENGTH:   win     = data[WIN_W-1:0];
                REG_DEBOUNCE_COUNT:  deb     = data[ABOVE_W-1:0];
                REG_DEAD_TIME:       dead    = data[DEAD_W-1:0];
                REG_RECORD_LENGTH:   rec_len = data[CNT_W-1:0];
                default: ;
            endcase
        endfunction

        // sample word accepted: run the slope test and queue the result word
        function void take_sample(logic [SAMPLE_W-1:0] smp, logic lst);
            int unsigned       w;
            longint            k;
            longint            lim;
            longint            delta;
            longint            na;
            logic [ADDR_W-1:0] rd;
            trig_word_t        want;
            w = 32'(win);
            if (w < 1) w = 1;
            if (w > MAX_WINDOW) w = MAX_WINDOW;
            rd = wr_ptr - w[ADDR_W-1:0];
            want.trigger = 1'b0;
            if (idx >= w) begin
                k   = longint'(idx) - longint'(w);
                lim = longint'(rec_len) - longint'(w) - longint'(dead);
                if (k >= longint'(next_start) && k < lim) begin
                    delta = longint'($signed(smp)) - longint'($signed(taps[rd]));
                    if (delta > longint'(thr)) begin
                        if (above < ABOVE_MAX) above++;
                        if (above == deb) begin
                            want.trigger = 1'b1;
                            above = '0;
                            if (found < CNT_MAX) found++;
                            na = k + longint'(dead) + 1;
                            next_start = (na > longint'(CNT_MAX)) ? CNT_MAX : na[CNT_W-1:0];
                        end
                    end else begin
                        above = '0;
                    end
                end
            end
            taps[wr_ptr] = smp;
            wr_ptr++;
            if (idx < CNT_MAX) idx++;
            want.count = found;
            want.done  = lst;
            due_triggers = {due_triggers, want};
            if (lst) clear_record();
        endfunction

        function void check_result(logic trig, logic [CNT_W-1:0] cnt, logic done);
            trig_word_t want;
            trig_word_t got;
            got.trigger = trig;
            got.count   = cnt;
            got.done    = done;
            if (due_triggers.size() == 0) begin
                errors++;
                $display("%0t: result word with none outstanding: trigger %0b count %0d done %0b",
                         $time, trig, cnt, done);
                return;
            end
            want = due_triggers.pop_front();
            if (got !== want) begin
                errors++;
                $display("%0t: result word mismatch: expected trigger %0b count %0d done %0b,",
                         $time, want.trigger, want.count, want.done,
                         " got trigger %0b count %0d done %0b", got.trigger, got.count,
                         got.done);
            end
        endfunction
    endclass

    // --------------------------------------------------------------------
    // DUT hook-up
    // --------------------------------------------------------------------
    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic [SAMPLE_W-1:0]   s_sample;
    logic                  s_last_sample;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_trigger;
    logic [CNT_W-1:0]      m_trigger_count;
    logic                  m_record_done;

    derivative_trigger_debounce_core u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample        (s_sample),
        .s_last_sample   (s_last_sample),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_trigger       (m_trigger),
        .m_trigger_count (m_trigger_count),
        .m_record_done   (m_record_done)
    );

    trigger_tracker sb;
    int             gap_max      = MAX_IDLE;
    int             stall_max    = MAX_IDLE;
    int             random_words = 0;
    bit             hold_off_req = 1'b0;

    // full-scale and bit-pattern words for the directed record
    logic [SAMPLE_W-1:0] corner_words [12] = '{
        24'h000000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'hFFFFFF,
        24'h000000, 24'h555555, 24'hAAAAAA, 24'h000001, 24'h7FFFFF, 24'h800000
    };

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // --------------------------------------------------------------------
    // Drivers. All tasks are entered and left on a falling edge, so every
    // input moves there and handshakes are seen at the rising edge.
    // --------------------------------------------------------------------

    // Offer one sample word, holding valid and payload until taken.
    // With a zero gap valid simply stays high into the next word.
    task automatic send_word(input logic [SAMPLE_W-1:0] smp, input logic lst);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_sample      <= smp;
        s_last_sample <= lst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.take_sample(smp, lst);
        @(negedge aclk);
    endtask

    // Drop the input and wait for every outstanding result word, then let the
    // clock run on so nothing is left in flight.
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.due_triggers.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // cfg_valid is left high for back-to-back writes; apply_setting lowers it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_reg(sel, data);
        @(negedge aclk);
    endtask

    // Whole register set, only ever from idle. Unused upper data bits carry
    // junk: the narrow registers must ignore them.
    task automatic apply_setting(input int thr, input int win, input int deb,
                                 input int dead, input int rl);
        logic [CFG_DATA_W-1:0] junk;
        settle();
        junk = CFG_DATA_W'($urandom());
        write_reg(REG_SLOPE_THRESHOLD, thr[THR_W-1:0]);
        write_reg(REG_WINDOW_LENGTH,   {junk[CFG_DATA_W-1:WIN_W], win[WIN_W-1:0]});
        write_reg(REG_DEBOUNCE_COUNT,  {junk[CFG_DATA_W-1:ABOVE_W], deb[ABOVE_W-1:0]});
        write_reg(REG_DEAD_TIME,       {junk[CFG_DATA_W-1:DEAD_W], dead[DEAD_W-1:0]});
        write_reg(REG_RECORD_LENGTH,   {junk[CFG_DATA_W-1:CNT_W], rl[CNT_W-1:0]});
        write_reg(REG_SPARE, junk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly short windows, small debounce and records so triggers are
    // frequent; now and then anything the register width allows.
    task automatic apply_random_setting();
        int thr;
        int win;
        int deb;
        int dead;
        int rl;
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 14)      thr = $urandom_range(0, 3000);
        else if (pick < 17) thr = -int'($urandom_range(0, 2000));
        else                thr = int'($urandom_range(0, 67108863)) - 33554432;
        pick = $urandom_range(0, 19);
        if (pick < 14)      win = $urandom_range(1, 24);
        else if (pick < 18) win = $urandom_range(25, 200);
        else                win = $urandom_range(0, 2047);
        pick = $urandom_range(0, 19);
        if (pick < 12)      deb = $urandom_range(1, 3);
        else if (pick < 16) deb = $urandom_range(0, 8);
        else                deb = $urandom_range(0, 2047);
        pick = $urandom_range(0, 19);
        if (pick < 10)      dead = $urandom_range(0, 20);
        else if (pick < 16) dead = $urandom_range(21, 300);
        else                dead = $urandom_range(0, 65535);
        pick = $urandom_range(0, 19);
        if (pick < 12)      rl = $urandom_range(20, 250);
        else if (pick < 16) rl = $urandom_range(1, 40);
        else                rl = $urandom_range(0, 16777215);
        apply_setting(thr, win, deb, dead, rl);
    endtask

    // Detector trace: baseline plus noise with decaying pulses of either
    // polarity, sized around the current threshold so deltas straddle it.
    // A noisy trace is raw full-range words instead.
    task automatic play_trace(input int n, input bit close, input bit noisy);
        int                  span;
        int                  nz;
        int                  level;
        int                  pulse;
        int                  x;
        logic [SAMPLE_W-1:0] word;
        span = int'(sb.thr);
        if (span < 1 || span > 1000000) span = 2000;
        nz    = span / 8 + 2;
        level = int'($urandom_range(0, 2000000)) - 1000000;
        pulse = 0;
        for (int i = 0; i < n; i++) begin
            if (noisy) begin
                word = SAMPLE_W'($urandom());
            end else begin
                if ($urandom_range(0, 11) == 0) begin
                    pulse = $urandom_range(0, 3 * span + 200);
                    if ($urandom_range(0, 3) == 0) pulse = -pulse;
                end else begin
                    pulse = pulse - pulse / 6;
                end
                x = level + pulse + int'($urandom_range(0, 2 * nz)) - nz;
                if (x > SAMPLE_MAX) x = SAMPLE_MAX;
                if (x < SAMPLE_MIN) x = SAMPLE_MIN;
                word = x[SAMPLE_W-1:0];
            end
            send_word(word, close && (i == n - 1));
            random_words++;
        end
    endtask

    // --------------------------------------------------------------------
    // Result side: per-word random stall, one long hold-off on request
    // --------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        stall   = 0;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                // sender keeps pushing meanwhile, so the pipe fills and s_ready drops
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_ready <= (stall == 0);
            if (stall > 0) stall--;
            @(posedge aclk);
            if (m_valid && m_ready) begin
                sb.check_result(m_trigger, m_trigger_count, m_record_done);
                stall = $urandom_range(0, stall_max);
            end
        end
    end

    // Hang guard: any channel moving a word resets the count
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // --------------------------------------------------------------------
    // Stimulus
    // --------------------------------------------------------------------
    initial begin : stimulus
        int n_rec;
        int pick;
        aresetn       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_valid       = 1'b0;
        s_sample      = '0;
        s_last_sample = 1'b0;
        sb = new();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset values untouched: window 20, debounce 2, dead time 200
        play_trace(60, 1'b1, 1'b0);

        // window of one, fire on every rising step: full-scale swings
        apply_setting(0, 1, 1, 0, 16);
        for (int i = 0; i < 12; i++) send_word(corner_words[i], i == 11);

        // ramp against debounce two and a short dead time; the record end
        // bound cuts evaluation off before the last samples
        apply_setting(0, 2, 2, 3, 12);
        for (int i = 0; i < 12; i++) send_word(SAMPLE_W'(i * 100), i == 11);

        // top threshold: no delta can exceed it
        apply_setting(33554431, 3, 1, 0, 1000);
        play_trace(20, 1'b1, 1'b1);

        // record too short for any position, then the one-sample record length
        apply_setting(100, 20, 1, 200, 50);
        play_trace(45, 1'b1, 1'b0);
        apply_setting(0, 1, 1, 0, 1);
        play_trace(5, 1'b1, 1'b1);

        // longest dead time: one trigger per record at most
        apply_setting(300, 4, 2, 65535, 16777215);
        play_trace(120, 1'b1, 0);

        // Full rate, no idling. Bottom threshold so every position is above;
        // window zero acts as one; debounce zero never fires while the counter
        // climbs. Raising debounce mid-record lets the running counter reach it.
        gap_max   = 0;
        stall_max = 0;
        apply_setting(-33554432, 0, 0, 0, 16777215);
        play_trace(30, 1'b0, 1'b1);
        apply_setting(-33554432, 0, 40, 0, 16777215);
        play_trace(20, 1'b1, 1'b1);

        // oversized window clamps to the delay-line depth; swap to the exact
        // depth mid-record, same effective window
        gap_max   = MAX_IDLE;
        stall_max = MAX_IDLE;
        apply_setting(2000, 2047, 1, 0, 16777215);
        play_trace(1030, 1'b0, 1'b0);
        apply_setting(2000, 1024, 1, 0, 16777215);
        play_trace(20, 1'b1, 1'b0);

        // back-pressure: result side holds off while words keep coming,
        // then the sender drains fully before finishing the record
        apply_random_setting();
        hold_off_req = 1'b1;
        gap_max      = 0;
        play_trace(40, 1'b0, 1'b0);
        settle();
        play_trace(30, 1'b1, 1'b0);
        gap_max      = MAX_IDLE;

        // random settings and records; some records run on across a setting change
        while (random_words < RANDOM_WORDS) begin
            gap_max   = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
            stall_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
            apply_random_setting();
            n_rec = $urandom_range(1, 4);
            for (int r = 0; r < n_rec; r++) begin
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    play_trace($urandom_range(10, 150), 1'b1, 1'b0);
                else if (pick < 8)
                    play_trace($urandom_range(5, 60), $urandom_range(0, 1), 1'b1);
                else
                    play_trace($urandom_range(1, 3), 1'b1, $urandom_range(0, 1));
            end
            if ($urandom_range(0, 2) == 0) begin
                play_trace($urandom_range(10, 80), 1'b0, 1'b0);
            end
        end

        settle();
        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.due_triggers.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/dtd_pkg.sv
hdl/dtd_ram.sv
hdl/derivative_trigger_debounce_core.sv
tb/sv/tb_derivative_trigger_debounce_core.sv
